// ===== hdl/ddt_pkg.sv =====
// shared types and constants for the discrete distribution table
// no dependencies
package ddt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int WEIGHT_BITS   = 16;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LSCAN,
    S_LRD,
    S_LDEC,
    S_LSHIFT,
    S_LWRITE,
    S_QSCAN,
    S_QRD,
    S_QDIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

// ===== hdl/ddt_div.sv =====
// serial restoring divider, one quotient bit per cycle
// depends on ddt_pkg
module ddt_div #(
  parameter int NW = 48,
  parameter int DW = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output ddt_pkg::div_ctl_t ctl,
  output logic [NW-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r;
  logic [DW:0]   rem_r;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [DW:0]   trial;

  assign trial = {rem_r[DW-1:0], q_r[NW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(NW);
      q_r    <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r   <= {q_r[NW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[NW-2:0], 1'b0};
      end
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) busy_r <= 1'b0;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign quo       = q_r;

endmodule

// ===== hdl/discrete_distribution_table_top.sv =====
// discrete distribution table: sorted (value, weight) store with pdf, cdf and quantile
// depends on ddt_pkg and ddt_div
//
// usage: one input channel (in_*) carries an action: clear, load or query.
// every item gives exactly one result item on the out_* channel.
// a load scans the table one entry at a time (memory read is registered),
// then shifts larger entries up one slot each; an equal value instead adds
// its weight to that entry. a query scans all entries in turn with
// one shared compare and accumulate unit, then runs two serial divisions of
// 16+SW bits each, one bit per cycle. in_ready is low while an item is
// in progress.
// the result is held in an output register until out_ready; a stalled
// receiver keeps the block from taking the next item.
// reset clears the entry count and total; table contents need no clearing.
module discrete_distribution_table_top #(
  parameter int TABLE_ENTRIES = ddt_pkg::TABLE_ENTRIES,
  parameter int WEIGHT_BITS   = ddt_pkg::WEIGHT_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic signed [31:0]     in_entry_value,
  input  logic [15:0]            in_entry_weight,
  input  logic signed [31:0]     in_query_x,
  input  logic [15:0]            in_query_p,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [16:0]            out_pdf,
  output logic [16:0]            out_cdf,
  output logic signed [31:0]     out_quantile,
  output logic                   out_quantile_found,
  output logic [1:0]             out_status
);

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = WEIGHT_BITS + CW;
  localparam int NW = SW + 16;
  localparam logic [WEIGHT_BITS-1:0] WMAX = {WEIGHT_BITS{1'b1}};

  ddt_pkg::state_t state_r, state_nxt;

  logic signed [31:0]      vmem [TABLE_ENTRIES];
  logic [WEIGHT_BITS-1:0]  wmem [TABLE_ENTRIES];
  logic signed [31:0]      vrd_r;
  logic [WEIGHT_BITS-1:0]  wrd_r;
  logic                    we;
  logic [AW-1:0]           waddr, raddr;
  logic signed [31:0]      wval;
  logic [WEIGHT_BITS-1:0]  wwt;

  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] total_r, total_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic signed [31:0]      val_r;
  logic signed [31:0]      qx_r;
  logic [WEIGHT_BITS-1:0]  wt_r;
  logic [15:0]             p_r;

  logic [SW-1:0] below_r, below_nxt, cum_r, cum_nxt;
  logic [WEIGHT_BITS-1:0] at_r, at_nxt;
  logic signed [31:0] quant_r, quant_nxt;
  logic found_r, found_nxt;
  logic [1:0] phase_r, phase_nxt;

  logic [16:0] pdf_r, pdf_nxt, cdf_r, cdf_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic          dstart;
  logic [NW-1:0] dnum, dquo;
  ddt_pkg::div_ctl_t dctl;

  logic [WEIGHT_BITS:0] wsum;
  logic [SW-1:0] cum_add;
  logic [NW-1:0] pt_prod;

  ddt_div #(.NW(NW), .DW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(total_r),
    .ctl(dctl), .quo(dquo)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[waddr] <= wval;
      wmem[waddr] <= wwt;
    end
    vrd_r <= vmem[raddr];
    wrd_r <= wmem[raddr];
  end

  assign wsum    = {1'b0, wrd_r} + {1'b0, wt_r};
  assign cum_add = cum_r + SW'(wrd_r);
  assign pt_prod = NW'(p_r) * NW'(total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ddt_pkg::S_IDLE;
      count_r  <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    below_r <= below_nxt;
    cum_r <= cum_nxt;
    at_r <= at_nxt;
    quant_r <= quant_nxt;
    found_r <= found_nxt;
    phase_r <= phase_nxt;
    pdf_r <= pdf_nxt;
    cdf_r <= cdf_nxt;
    status_r <= status_nxt;
    if (in_valid && in_ready) begin
      val_r <= in_entry_value;
      qx_r  <= in_query_x;
      wt_r  <= (in_entry_weight > 16'(WMAX)) ? WMAX : WEIGHT_BITS'(in_entry_weight);
      p_r   <= in_query_p;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    total_nxt = total_r;
    ovalid_nxt = ovalid_r;
    idx_nxt = idx_r;
    below_nxt = below_r;
    cum_nxt = cum_r;
    at_nxt = at_r;
    quant_nxt = quant_r;
    found_nxt = found_r;
    phase_nxt = phase_r;
    pdf_nxt = pdf_r;
    cdf_nxt = cdf_r;
    status_nxt = status_r;
    in_ready = 1'b0;
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    raddr = idx_r[AW-1:0];
    wval = vrd_r;
    wwt = wrd_r;
    dstart = 1'b0;
    dnum = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ddt_pkg::S_IDLE: begin
        in_ready = !ovalid_r;
        if (in_valid && !ovalid_r) begin
          idx_nxt = '0;
          below_nxt = '0;
          cum_nxt = '0;
          at_nxt = '0;
          quant_nxt = '0;
          found_nxt = 1'b0;
          pdf_nxt = '0;
          cdf_nxt = '0;
          status_nxt = ddt_pkg::ST_OK;
          unique case (in_action)
            ddt_pkg::ACT_CLEAR: begin
              count_nxt = '0;
              total_nxt = '0;
              state_nxt = ddt_pkg::S_DONE;
            end
            ddt_pkg::ACT_LOAD: state_nxt = ddt_pkg::S_LSCAN;
            ddt_pkg::ACT_QUERY: begin
              if (total_r == '0) begin
                status_nxt = ddt_pkg::ST_EMPTY;
                state_nxt = ddt_pkg::S_DONE;
              end else begin
                state_nxt = ddt_pkg::S_QSCAN;
              end
            end
            default: state_nxt = ddt_pkg::S_DONE;
          endcase
        end
      end
      ddt_pkg::S_LSCAN: begin
        if (idx_r == count_r) begin
          if (count_r == CW'(TABLE_ENTRIES)) begin
            status_nxt = ddt_pkg::ST_FULL;
            state_nxt = ddt_pkg::S_DONE;
          end else begin
            state_nxt = ddt_pkg::S_LWRITE;
          end
        end else begin
          state_nxt = ddt_pkg::S_LRD;
        end
      end
      ddt_pkg::S_LRD: begin
        if (vrd_r < val_r) begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = ddt_pkg::S_LSCAN;
        end else if (vrd_r == val_r) begin
          we = 1'b1;
          wval = val_r;
          wwt = wsum[WEIGHT_BITS] ? WMAX : wsum[WEIGHT_BITS-1:0];
          total_nxt = total_r - SW'(wrd_r) + SW'(wwt);
          state_nxt = ddt_pkg::S_DONE;
        end else if (count_r == CW'(TABLE_ENTRIES)) begin
          status_nxt = ddt_pkg::ST_FULL;
          state_nxt = ddt_pkg::S_DONE;
        end else begin
          cum_nxt = SW'(idx_r);
          idx_nxt = count_r;
          state_nxt = ddt_pkg::S_LDEC;
        end
      end
      ddt_pkg::S_LDEC: begin
        if (idx_r == cum_r[CW-1:0]) begin
          state_nxt = ddt_pkg::S_LWRITE;
        end else begin
          raddr = AW'(idx_r - 1'b1);
          state_nxt = ddt_pkg::S_LSHIFT;
        end
      end
      ddt_pkg::S_LSHIFT: begin
        we = 1'b1;
        idx_nxt = idx_r - 1'b1;
        state_nxt = ddt_pkg::S_LDEC;
      end
      ddt_pkg::S_LWRITE: begin
        we = 1'b1;
        wval = val_r;
        wwt = wt_r;
        total_nxt = total_r + SW'(wt_r);
        count_nxt = count_r + 1'b1;
        state_nxt = ddt_pkg::S_DONE;
      end
      ddt_pkg::S_QSCAN: begin
        if (idx_r == count_r) begin
          phase_nxt = 2'd0;
          dstart = 1'b1;
          dnum = NW'({SW'(at_r), 16'd0});
          state_nxt = ddt_pkg::S_QDIV;
        end else begin
          state_nxt = ddt_pkg::S_QRD;
        end
      end
      ddt_pkg::S_QRD: begin
        if (vrd_r < qx_r) below_nxt = below_r + SW'(wrd_r);
        if (vrd_r == qx_r) at_nxt = wrd_r;
        cum_nxt = cum_add;
        if (!found_r && ({cum_add, 16'd0} > pt_prod)) begin
          found_nxt = 1'b1;
          quant_nxt = vrd_r;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = ddt_pkg::S_QSCAN;
      end
      ddt_pkg::S_QDIV: begin
        if (!dctl.busy) begin
          if (phase_r == 2'd0) begin
            pdf_nxt = dquo[16:0];
            phase_nxt = 2'd1;
            dstart = 1'b1;
            dnum = NW'({below_r, 16'd0});
          end else begin
            cdf_nxt = dquo[16:0];
            state_nxt = ddt_pkg::S_DONE;
          end
        end
      end
      ddt_pkg::S_DONE: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = ddt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ddt_pkg::S_IDLE;
    endcase
  end

  assign out_valid = ovalid_r;
  assign out_pdf = pdf_r;
  assign out_cdf = cdf_r;
  assign out_quantile = quant_r;
  assign out_quantile_found = found_r;
  assign out_status = status_r;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_ENTRIES)) else $error("entry count over table depth");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ddt_pkg::S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (total_r == '0)) else $error("weight with no entries");
`endif

endmodule
